FILE: hdl/bsuf_pkg.sv
// Package for the byte size unit formatter.
// Holds the unit band type, the decimal band limits and the ASCII codes.
// No dependencies.
`default_nettype none

package bsuf_pkg;

  typedef enum logic [2:0] {
    BAND_B,
    BAND_K,
    BAND_M,
    BAND_G,
    BAND_T,
    BAND_P,
    BAND_E
  } band_t;

  localparam logic [63:0] LIM_K = 64'd1000;
  localparam logic [63:0] LIM_M = 64'd1000000;
  localparam logic [63:0] LIM_G = 64'd1000000000;
  localparam logic [63:0] LIM_T = 64'd1000000000000;
  localparam logic [63:0] LIM_P = 64'd1000000000000000;
  localparam logic [63:0] LIM_E = 64'd1000000000000000000;

  localparam logic [5:0] DIGIT_BASE = 6'd48;

  localparam logic [6:0] CHAR_B = 7'd66;
  localparam logic [6:0] CHAR_K = 7'd75;
  localparam logic [6:0] CHAR_M = 7'd77;
  localparam logic [6:0] CHAR_G = 7'd71;
  localparam logic [6:0] CHAR_T = 7'd84;
  localparam logic [6:0] CHAR_P = 7'd80;
  localparam logic [6:0] CHAR_E = 7'd69;

  // reciprocals of 10, 100 and 1000, exact for values below 10000
  localparam logic [12:0] RECIP_10   = 13'd6554;
  localparam logic [12:0] RECIP_100  = 13'd5243;
  localparam logic [13:0] RECIP_1000 = 14'd8389;

  function automatic logic [6:0] unit_char(input band_t band);
    logic [6:0] c;
    unique case (band)
      BAND_B:  c = CHAR_B;
      BAND_K:  c = CHAR_K;
      BAND_M:  c = CHAR_M;
      BAND_G:  c = CHAR_G;
      BAND_T:  c = CHAR_T;
      BAND_P:  c = CHAR_P;
      BAND_E:  c = CHAR_E;
      default: c = CHAR_E;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/byte_size_unit_formatter_top.sv
// Top level of the byte size unit formatter.
// Input register, band select, tenths scaling, digit split, result register.
// Depends on bsuf_pkg.
`default_nettype none

// The block turns a 64-bit byte count into four ASCII digits (hundreds, tens,
// ones, tenths, leading zeros shown) and a unit letter B, K, M, G, T, P or E,
// chosen by decimal limits and scaled by powers of 1024, truncating. It takes
// one transaction per cycle while the out_ channel does not stall. A count
// accepted into the input register moves to the result register once that
// register is empty or its result is being taken, and its result then shows
// on the out_ channel until it is taken. While a result waits, the input
// register takes one more transaction and then holds in_ready low.
module byte_size_unit_formatter_top
  import bsuf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [63:0] in_byte_count,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [5:0]       out_hundreds_char,
  output logic [5:0]       out_tens_char,
  output logic [5:0]       out_ones_char,
  output logic [5:0]       out_tenths_char,
  output logic [6:0]       out_unit_char
);

  logic        in_valid_r;
  logic [63:0] count_r;
  logic        out_valid_r;
  logic [5:0]  hundreds_r, tens_r, ones_r, tenths_r;
  logic [6:0]  unit_r;

  logic        out_load;
  band_t       band;
  logic [19:0] pre;
  logic [23:0] prod;
  logic [13:0] scaled;
  logic [26:0] m10;
  logic [32:0] m100;
  logic [27:0] m1000;
  logic [13:0] q1;
  logic [13:0] q2;
  logic [13:0] q3;
  logic [3:0]  d0, d1, d2, d3;

  assign out_load = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || out_load;

  always_comb begin
    priority if (count_r < LIM_K) begin
      band = BAND_B;
      pre  = count_r[19:0];
    end else if (count_r < LIM_M) begin
      band = BAND_K;
      pre  = count_r[19:0];
    end else if (count_r < LIM_G) begin
      band = BAND_M;
      pre  = count_r[29:10];
    end else if (count_r < LIM_T) begin
      band = BAND_G;
      pre  = count_r[39:20];
    end else if (count_r < LIM_P) begin
      band = BAND_T;
      pre  = count_r[49:30];
    end else if (count_r < LIM_E) begin
      band = BAND_P;
      pre  = count_r[59:40];
    end else begin
      band = BAND_E;
      pre  = {6'd0, count_r[63:50]};
    end
  end

  always_comb begin
    prod   = {pre, 3'd0} + {3'd0, pre, 1'd0} + 24'd0;
    scaled = (band == BAND_B) ? prod[13:0] : prod[23:10];
    m10    = {13'd0, scaled} * {14'd0, RECIP_10};
    m100   = {19'd0, scaled} * {20'd0, RECIP_100};
    m1000  = {14'd0, scaled} * {14'd0, RECIP_1000};
    q1     = {4'd0, m10[25:16]};
    q2     = {7'd0, m100[25:19]};
    q3     = {10'd0, m1000[26:23]};
    d0     = 4'(scaled - ((q1 << 3) + (q1 << 1)));
    d1     = 4'(q1 - ((q2 << 3) + (q2 << 1)));
    d2     = 4'(q2 - ((q3 << 3) + (q3 << 1)));
    d3     = q3[3:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      count_r <= in_byte_count;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      hundreds_r <= DIGIT_BASE + {2'd0, d3};
      tens_r     <= DIGIT_BASE + {2'd0, d2};
      ones_r     <= DIGIT_BASE + {2'd0, d1};
      tenths_r   <= DIGIT_BASE + {2'd0, d0};
      unit_r     <= unit_char(band);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_hundreds_char = hundreds_r;
  assign out_tens_char     = tens_r;
  assign out_ones_char     = ones_r;
  assign out_tenths_char   = tenths_r;
  assign out_unit_char     = unit_r;

  a_e_band_small: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_unit_char == CHAR_E |-> out_hundreds_char == DIGIT_BASE)
    else $error("band E result shows a nonzero hundreds digit");

  a_digits_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_tenths_char >= DIGIT_BASE && out_tenths_char <= 6'd57
                  && out_ones_char >= DIGIT_BASE && out_ones_char <= 6'd57
                  && out_tens_char >= DIGIT_BASE && out_tens_char <= 6'd57)
    else $error("result digit out of range");

  a_stage_fill: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> in_valid_r)
    else $error("accepted transaction lost in input register");

  a_stage_drain: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !out_valid_r |=> out_valid_r)
    else $error("input register did not advance to result register");

endmodule

`default_nettype wire
